// ----- sv/klstk_pkg.sv -----
`default_nettype none
package klstk_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_GIVEN  = 3'd4
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  key;
    logic signed [WORD_W-1:0]  data;
    logic [CNT_W-1:0]          count;
    logic                      empty;
    logic                      last;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/klstk_if.sv -----
`default_nettype none
interface klstk_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic signed [klstk_pkg::WORD_W-1:0]   in_key;
  logic signed [klstk_pkg::WORD_W-1:0]   in_data;

  modport source (output valid, output opcode, output in_key, output in_data, input ready);
  modport sink   (input valid, input opcode, input in_key, input in_data, output ready);
endinterface

interface klstk_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            status;
  logic signed [klstk_pkg::WORD_W-1:0]   out_key;
  logic signed [klstk_pkg::WORD_W-1:0]   out_data;
  logic [klstk_pkg::CNT_W-1:0]           entry_count;
  logic                                  is_empty;
  logic                                  last;

  modport source (output valid, output status, output out_key, output out_data,
                  output entry_count, output is_empty, output last, input ready);
  modport sink   (input valid, input status, input out_key, input out_data,
                  input entry_count, input is_empty, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/klstk_ram.sv -----
`default_nettype none
module klstk_ram #(
  parameter int WIDTH   = 64,
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/klstk_engine.sv -----
`default_nettype none
module klstk_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  klstk_req_if.sink               req,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output klstk_pkg::result_t      res
);

  localparam int AW = klstk_pkg::ADDR_W;
  localparam int CW = klstk_pkg::CNT_W;
  localparam int WW = klstk_pkg::WORD_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RWAIT, S_EMIT} state_t;

  state_t                     state, state_next;
  klstk_pkg::op_t             op, op_next;
  logic signed [WW-1:0]       key, key_next;
  logic signed [WW-1:0]       data, data_next;
  logic [CW-1:0]              count, count_next;
  logic [CW-1:0]              idx, idx_next;
  logic                       pend, pend_next;
  klstk_pkg::result_t         res_next;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [2*WW-1:0]            rdata;
  logic [CW-1:0]              cnt_m1;
  logic [CW-1:0]              idx_m1;
  logic                       issue;

  assign cnt_m1    = count - CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign issue     = (idx < count);
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  klstk_ram #(
    .WIDTH   (2 * WW),
    .ENTRIES (klstk_pkg::DEPTH),
    .AW      (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({key, data}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    op_next    = op;
    key_next   = key;
    data_next  = data;
    count_next = count;
    idx_next   = idx;
    pend_next  = 1'b0;
    res_next   = res;
    we         = 1'b0;
    waddr      = count[AW-1:0];
    raddr      = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        // The top entry is read speculatively so a pop, peek or display finds it in the cycle after acceptance.
        raddr = cnt_m1[AW-1:0];
        if (req.valid) begin
          op_next   = klstk_pkg::op_t'(req.opcode);
          key_next  = req.in_key;
          data_next = req.in_data;
          if (klstk_pkg::op_t'(req.opcode) == klstk_pkg::OP_PUSH) begin
            idx_next   = '0;
            state_next = S_SCAN;
          end else if (count == '0) begin
            res_next.status = klstk_pkg::ST_EMPTY;
            res_next.key    = '0;
            res_next.data   = '0;
            res_next.count  = '0;
            res_next.empty  = 1'b1;
            res_next.last   = 1'b1;
            state_next      = S_EMIT;
          end else begin
            idx_next   = cnt_m1;
            state_next = S_RWAIT;
          end
        end
      end

      S_SCAN: begin
        // One read is issued per cycle; the key read in the previous cycle is compared now.
        res_next.key  = '0;
        res_next.data = '0;
        res_next.last = 1'b1;
        if (pend && (rdata[2*WW-1:WW] == key)) begin
          res_next.status = klstk_pkg::ST_DUP;
          res_next.count  = count;
          res_next.empty  = (count == '0);
          state_next      = S_EMIT;
        end else if (!issue && !pend) begin
          if (count == CW'(klstk_pkg::DEPTH)) begin
            res_next.status = klstk_pkg::ST_FULL;
            res_next.count  = count;
            res_next.empty  = 1'b0;
          end else begin
            we              = 1'b1;
            count_next      = count + CW'(1);
            res_next.status = klstk_pkg::ST_PUSHED;
            res_next.count  = count + CW'(1);
            res_next.empty  = 1'b0;
          end
          state_next = S_EMIT;
        end else begin
          pend_next = issue;
          if (issue) begin
            idx_next = idx + CW'(1);
          end
        end
      end

      S_RWAIT: begin
        res_next.status = klstk_pkg::ST_GIVEN;
        res_next.key    = rdata[2*WW-1:WW];
        res_next.data   = rdata[WW-1:0];
        res_next.last   = (op != klstk_pkg::OP_DISPLAY) || (idx == '0);
        if (op == klstk_pkg::OP_POP) begin
          count_next     = cnt_m1;
          res_next.count = cnt_m1;
          res_next.empty = (cnt_m1 == '0);
        end else begin
          res_next.count = count;
          res_next.empty = 1'b0;
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        raddr = idx_m1[AW-1:0];
        if (res_ready) begin
          if ((op == klstk_pkg::OP_DISPLAY) && (res.status == klstk_pkg::ST_GIVEN) &&
              (idx != '0)) begin
            idx_next   = idx_m1;
            state_next = S_RWAIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    op   <= op_next;
    key  <= key_next;
    data <= data_next;
    idx  <= idx_next;
    res  <= res_next;
  end

endmodule
`default_nettype wire

// ----- sv/keyed_lifo_stack.sv -----
// Bounded last-in-first-out stack of unique-key/data pairs.
// Requests arrive on req (opcode, in_key, in_data) and results leave on rsp
// (status, out_key, out_data, entry_count, is_empty, last); both channels move
// one transaction on a clock edge where valid and ready are high.
// A push, pop or peek gives one result. A display gives one result per stored
// entry, top first, with last set on the final one; on an empty stack it gives
// a single underflow result.
// One request is processed at a time. The pairs live in a single memory with
// one read port and a registered read, and that port sets the order of work:
// a push walks the stored keys for duplicates, bottom first, and stops at the
// first match; a pop or peek reads the top entry, and a display reads the
// entries one after another from the top. A pop, peek or display on an empty
// stack gives its underflow result without a memory read.
// Each result sits in an output register; the next request is accepted while
// it waits. When rsp.ready is low the engine holds its next result and stops.
// Reset (rst, synchronous) empties the stack and drops any pending result.
// Memory contents are not cleared; only entries below the count are ever used.
`default_nettype none
module keyed_lifo_stack (
  input  wire logic    clk,
  input  wire logic    rst,
  klstk_req_if.sink    req,
  klstk_rsp_if.source  rsp
);

  logic                 res_valid;
  logic                 res_ready;
  klstk_pkg::result_t   res;
  logic                 ovalid;
  klstk_pkg::result_t   obuf;

  assign res_ready = !ovalid || rsp.ready;

  klstk_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      obuf <= res;
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.status      = obuf.status;
  assign rsp.out_key     = obuf.key;
  assign rsp.out_data    = obuf.data;
  assign rsp.entry_count = obuf.count;
  assign rsp.is_empty    = obuf.empty;
  assign rsp.last        = obuf.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_count <= klstk_pkg::CNT_W'(klstk_pkg::DEPTH)))
    else $error("entry count beyond stack depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != klstk_pkg::ST_GIVEN)) |->
      ((rsp.out_key == '0) && (rsp.out_data == '0) && rsp.last))
    else $error("non-entry result carries payload or is not last");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

endmodule
`default_nettype wire
